/* rtl/core/assert_macros.svh */
// Assertion macros shared by the edge table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property prop must hold at every rising edge of clk while rst is low.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression expr must never be true at a rising edge of clk while rst is low.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* rtl/core/dget_pkg.sv */
// Package of types, codes and helpers for the dynamic graph edge table.
`default_nettype none
package dget_pkg;

   localparam int MAX_NODES = 64;
   // Node indices are six bits wide, so the count can never pass 64.
   localparam int NODE_CAP  = (MAX_NODES < 64) ? MAX_NODES : 64;
   localparam int NODE_W    = 6;
   localparam int CNT_W     = 7;
   localparam int ROWS      = 1 << NODE_W;
   localparam int ROW_W     = 1 << NODE_W;

   localparam logic [CNT_W-1:0] NODE_CAP_C = CNT_W'(NODE_CAP);

   typedef logic [1:0] status_type;
   typedef logic [2:0] req_code_type;

   localparam status_type STAT_OK     = 2'd0;
   localparam status_type STAT_RANGE  = 2'd1;
   localparam status_type STAT_UNUSED = 2'd2;
   localparam status_type STAT_FULL   = 2'd3;

   localparam req_code_type REQ_ADD    = 3'd0;
   localparam req_code_type REQ_REMOVE = 3'd1;
   localparam req_code_type REQ_QUERY  = 3'd2;
   localparam req_code_type REQ_ALLOC  = 3'd3;
   localparam req_code_type REQ_DELETE = 3'd4;

   // Checks one node index against the current count and the free map.
   function automatic status_type check_node(input logic [NODE_W-1:0] k,
                                             input logic [CNT_W-1:0]  cnt,
                                             input logic [ROW_W-1:0]  free);
      status_type st;
      st = STAT_OK;
      if ({1'b0, k} >= cnt) begin
         st = STAT_RANGE;
      end else if (free[k]) begin
         st = STAT_UNUSED;
      end
      return st;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/dget_ram.sv */
// Generic single write port, single read port RAM with a registered read.
`default_nettype none
module dget_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/dynamic_graph_edge_table_top.sv */
// Top level of the dynamic graph edge table: sequencer, node bookkeeping and result register.
`default_nettype none
`include "assert_macros.svh"

// The block stores a directed graph of up to 64 nodes as a 64 x 64 bit matrix held in a
// single RAM, one row per source node. A request beat is taken only while the sequencer is
// idle, and each request produces exactly one response beat, held in an output register so
// that the next request can be taken while the response still waits. Edge add, remove and
// query pass through a RAM read, a read-modify-write and the response; a request with a bad
// index, an unknown request code or an allocation that extends the count goes straight to
// the response; an allocation that reuses a freed index first scans the free map one bit a
// cycle from the lowest index; a node deletion sweeps over all 64 rows through the one RAM
// port pair, one row read and one row written back each cycle. Row valid flags stand in
// for clearing the RAM, so reset and a write of initial_nodes take effect at once and no
// clearing pass is needed. A write of initial_nodes is saturated to the node cap.
module dynamic_graph_edge_table_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [dget_pkg::CNT_W-1:0]      csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [2:0]                      req_type,
   input  wire logic [dget_pkg::NODE_W-1:0]     req_node_a,
   input  wire logic [dget_pkg::NODE_W-1:0]     req_node_b,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_edge_present,
   output logic [dget_pkg::NODE_W-1:0]          rsp_new_node,
   output logic [dget_pkg::CNT_W-1:0]           rsp_used_count,
   output logic [dget_pkg::CNT_W-1:0]           rsp_total_count
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EDGE = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_DEL  = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   logic [2:0]                       state_ff, state_in;
   dget_pkg::req_code_type           type_ff, type_in;
   logic [dget_pkg::NODE_W-1:0]      a_ff, a_in;
   logic [dget_pkg::NODE_W-1:0]      b_ff, b_in;
   // Shared step counter: free map scan index, and row read pointer of the deletion sweep.
   logic [dget_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                             pend_ff, pend_in;
   logic [dget_pkg::NODE_W-1:0]      wrrow_ff, wrrow_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [dget_pkg::ROWS-1:0]        row_vld_ff, row_vld_in;
   logic [dget_pkg::ROW_W-1:0]       free_ff, free_in;
   logic [dget_pkg::CNT_W-1:0]       freecnt_ff, freecnt_in;
   logic [dget_pkg::CNT_W-1:0]       count_ff, count_in;
   dget_pkg::status_type             st_ff, st_in;
   logic                             pres_ff, pres_in;
   logic [dget_pkg::NODE_W-1:0]      fresh_ff, fresh_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   dget_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic                             rsp_pres_ff, rsp_pres_in;
   logic [dget_pkg::NODE_W-1:0]      rsp_new_ff, rsp_new_in;
   logic [dget_pkg::CNT_W-1:0]       rsp_used_ff, rsp_used_in;
   logic [dget_pkg::CNT_W-1:0]       rsp_total_ff, rsp_total_in;

   logic                             ram_we;
   logic [dget_pkg::NODE_W-1:0]      ram_wr_addr;
   logic [dget_pkg::ROW_W-1:0]       ram_wr_data;
   logic                             ram_re;
   logic [dget_pkg::NODE_W-1:0]      ram_rd_addr;
   logic [dget_pkg::ROW_W-1:0]       ram_rd_data;

   logic                             accept;
   dget_pkg::status_type             chk;
   logic [dget_pkg::ROW_W-1:0]       row_cur;
   logic [dget_pkg::ROW_W-1:0]       bit_b;
   logic [dget_pkg::ROW_W-1:0]       col_mask;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // A row that has not been written since reset or the last initialisation reads as zero.
   assign row_cur  = rd_vld_ff ? ram_rd_data : '0;
   assign bit_b    = dget_pkg::ROW_W'(1) << b_ff;
   assign col_mask = ~(dget_pkg::ROW_W'(1) << a_ff);

   dget_ram #(
      .WIDTH (dget_pkg::ROW_W),
      .DEPTH (dget_pkg::ROWS)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      wrrow_in     = wrrow_ff;
      rd_vld_in    = rd_vld_ff;
      row_vld_in   = row_vld_ff;
      free_in      = free_ff;
      freecnt_in   = freecnt_ff;
      count_in     = count_ff;
      st_in        = st_ff;
      pres_in      = pres_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pres_in  = rsp_pres_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_total_in = rsp_total_ff;
      ram_we       = 1'b0;
      ram_wr_addr  = a_ff;
      ram_wr_data  = '0;
      ram_re       = 1'b0;
      ram_rd_addr  = cnt_ff[dget_pkg::NODE_W-1:0];
      chk          = dget_pkg::STAT_OK;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               type_in  = req_type;
               a_in     = req_node_a;
               b_in     = req_node_b;
               st_in    = dget_pkg::STAT_OK;
               pres_in  = 1'b0;
               fresh_in = '0;
               state_in = ST_RESP;
               case (req_type)
                  dget_pkg::REQ_ADD, dget_pkg::REQ_REMOVE, dget_pkg::REQ_QUERY: begin
                     // Source is checked before destination; the first failure wins.
                     chk = dget_pkg::check_node(req_node_a, count_ff, free_ff);
                     if (chk == dget_pkg::STAT_OK) begin
                        chk = dget_pkg::check_node(req_node_b, count_ff, free_ff);
                     end
                     st_in = chk;
                     if (chk == dget_pkg::STAT_OK) begin
                        ram_re      = 1'b1;
                        ram_rd_addr = req_node_a;
                        rd_vld_in   = row_vld_ff[req_node_a];
                        state_in    = ST_EDGE;
                     end
                  end
                  dget_pkg::REQ_ALLOC: begin
                     if (free_ff != '0) begin
                        cnt_in   = '0;
                        state_in = ST_SCAN;
                     end else if (count_ff < dget_pkg::NODE_CAP_C) begin
                        fresh_in = count_ff[dget_pkg::NODE_W-1:0];
                        count_in = count_ff + dget_pkg::CNT_W'(1);
                     end else begin
                        st_in = dget_pkg::STAT_FULL;
                     end
                  end
                  dget_pkg::REQ_DELETE: begin
                     chk   = dget_pkg::check_node(req_node_a, count_ff, free_ff);
                     st_in = chk;
                     if (chk == dget_pkg::STAT_OK) begin
                        cnt_in   = '0;
                        pend_in  = 1'b0;
                        state_in = ST_DEL;
                     end
                  end
                  default: begin
                     // Unknown request codes are answered with OK and change nothing.
                  end
               endcase
            end
         end
         ST_EDGE: begin
            case (type_ff)
               dget_pkg::REQ_ADD: begin
                  ram_we             = 1'b1;
                  ram_wr_addr        = a_ff;
                  ram_wr_data        = row_cur | bit_b;
                  row_vld_in[a_ff]   = 1'b1;
               end
               dget_pkg::REQ_REMOVE: begin
                  ram_we             = 1'b1;
                  ram_wr_addr        = a_ff;
                  ram_wr_data        = row_cur & ~bit_b;
                  row_vld_in[a_ff]   = 1'b1;
               end
               default: begin
                  pres_in = row_cur[b_ff];
               end
            endcase
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (free_ff[cnt_ff[dget_pkg::NODE_W-1:0]]) begin
               free_in[cnt_ff[dget_pkg::NODE_W-1:0]] = 1'b0;
               freecnt_in = freecnt_ff - dget_pkg::CNT_W'(1);
               fresh_in   = cnt_ff[dget_pkg::NODE_W-1:0];
               state_in   = ST_RESP;
            end else begin
               cnt_in = cnt_ff + dget_pkg::CNT_W'(1);
            end
         end
         ST_DEL: begin
            // Read row n, write back row n-1 with column a cleared; row a itself is zeroed.
            if (!cnt_ff[dget_pkg::NODE_W]) begin
               ram_re      = 1'b1;
               ram_rd_addr = cnt_ff[dget_pkg::NODE_W-1:0];
               rd_vld_in   = row_vld_ff[cnt_ff[dget_pkg::NODE_W-1:0]];
               wrrow_in    = cnt_ff[dget_pkg::NODE_W-1:0];
               cnt_in      = cnt_ff + dget_pkg::CNT_W'(1);
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               ram_we               = 1'b1;
               ram_wr_addr          = wrrow_ff;
               ram_wr_data          = (wrrow_ff == a_ff) ? '0 : (row_cur & col_mask);
               row_vld_in[wrrow_ff] = 1'b1;
            end
            if (cnt_ff[dget_pkg::NODE_W] && !pend_ff) begin
               free_in[a_ff] = 1'b1;
               freecnt_in    = freecnt_ff + dget_pkg::CNT_W'(1);
               state_in      = ST_RESP;
            end
         end
         ST_RESP: begin
            // Counts were updated on entry to this state, so they already reflect this request.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_pres_in   = pres_ff;
               rsp_new_in    = fresh_ff;
               rsp_used_in   = count_ff - freecnt_ff;
               rsp_total_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Initialisation wipes every row and free mark at once and sets the count.
      if (csr_we) begin
         row_vld_in = '0;
         free_in    = '0;
         freecnt_in = '0;
         count_in   = (csr_wdata > dget_pkg::NODE_CAP_C) ? dget_pkg::NODE_CAP_C : csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         row_vld_ff   <= '0;
         free_ff      <= '0;
         freecnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         row_vld_ff   <= row_vld_in;
         free_ff      <= free_in;
         freecnt_ff   <= freecnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      cnt_ff        <= cnt_in;
      wrrow_ff      <= wrrow_in;
      rd_vld_ff     <= rd_vld_in;
      st_ff         <= st_in;
      pres_ff       <= pres_in;
      fresh_ff      <= fresh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pres_ff   <= rsp_pres_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_edge_present = rsp_pres_ff;
   assign rsp_new_node     = rsp_new_ff;
   assign rsp_used_count   = rsp_used_ff;
   assign rsp_total_count  = rsp_total_ff;

   // The node count never passes the cap, and the free nodes never outnumber it.
   `ASSERT_NEVER(a_count_cap, clock, reset, count_ff > dget_pkg::NODE_CAP_C)
   `ASSERT_NEVER(a_free_le_count, clock, reset, freecnt_ff > count_ff)
   // The matrix is only written while an edge or deletion request is in progress.
   `ASSERT_CLK(a_no_idle_write, clock, reset, (state_ff == ST_IDLE) |-> !ram_we)
   // A response beat appears only after the sequencer has passed through its response state.
   `ASSERT_CLK(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))

endmodule
`default_nettype wire
